/* src/assert_macros.svh */
// Assertion macros shared by the pipe endpoint engine RTL.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle
`define PFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pfe assertion failed");
// Check that a condition implies another in the following cycle
`define PFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pfe assertion failed");
`else
`define PFE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/pfe_pkg.sv */
// Shared constants, codes and control/status structs of the pipe endpoint engine.
// Used by pfe_ctrl, pfe_dp and pipe_fifo_endpoint_engine; depends on nothing.
package pfe_pkg;

  // Sizing
  localparam int BUFFER_BYTES   = 4096;
  localparam int MAX_READ_BURST = 64;
  localparam int PTR_W          = $clog2(BUFFER_BYTES);
  localparam int HELD_W         = $clog2(BUFFER_BYTES + 1);
  localparam int BURST_W        = $clog2(MAX_READ_BURST + 1);
  localparam int CMP_W          = (HELD_W > BURST_W) ? HELD_W : BURST_W;

  // Field widths
  localparam int KIND_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int RLEN_W  = 7;
  localparam int STAT_W  = 3;
  localparam int IDENT_W = 32;
  localparam int FILL_W  = 13;
  localparam int CNT_W   = 16;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_FIELD_W = BYTE_W + IDENT_W + FILL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_TUSER_W = STAT_W + 1;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    K_CREATE    = 4'd0,
    K_ACQ_READ  = 4'd1,
    K_ACQ_WRITE = 4'd2,
    K_ACQ_REF   = 4'd3,
    K_CLS_READ  = 4'd4,
    K_CLS_WRITE = 4'd5,
    K_WRITE     = 4'd6,
    K_READ      = 4'd7,
    K_ABORT     = 4'd8
  } kind_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    S_OK       = 3'd0,
    S_EOF      = 3'd1,
    S_BLOCK    = 3'd2,
    S_BROKEN   = 3'd3,
    S_NOT_OPEN = 3'd4
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic pop;     // deliver one byte of a read burst
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic burst_req;  // offered item is a read that delivers bytes
    logic last_byte;  // burst has one byte left
  } dp_stat_t;

endpackage

/* src/pfe_ctrl.sv */
// Controller of the pipe endpoint engine: idle/burst state machine.
// Depends on pfe_pkg; drives commands into pfe_dp and reads its status.
module pfe_ctrl import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == ST_IDLE) && stat.slot_free;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: enter burst on a read that delivers bytes, leave after its last byte
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.burst_req) begin
          state_nxt = ST_BURST;
        end
      end
      ST_BURST: begin
        if (stat.slot_free && stat.last_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: take items when idle, pop bytes while bursting
  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = stat.slot_free;
        cmd.accept = accept;
      end
      ST_BURST: begin
        cmd.pop = stat.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

/* src/pfe_dp.sv */
// Datapath of the pipe endpoint engine: byte store, pointers, counts and result register.
// Depends on pfe_pkg; commanded by pfe_ctrl.
module pfe_dp import pfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [KIND_W-1:0]  kind,
  input  logic [BYTE_W-1:0]  data_in,
  input  logic [RLEN_W-1:0]  read_len,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [BYTE_W-1:0]  out_data,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_last,
  output logic               out_released,
  output logic [IDENT_W-1:0] out_ident,
  output logic [FILL_W-1:0]  out_fill
);

  // Saturating count steps and ring pointer advance
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - CNT_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_BYTES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Byte store
  logic [BYTE_W-1:0] mem_r [BUFFER_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic              wr_en;
  logic [PTR_W-1:0]  rd_addr;

  // Pipe state
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]   rdr_r, rdr_nxt;
  logic [CNT_W-1:0]   wrr_r, wrr_nxt;
  logic [CNT_W-1:0]   refs_r, refs_nxt;
  logic               live_r, live_nxt;
  logic [IDENT_W-1:0] cur_id_r, cur_id_nxt;
  logic [IDENT_W-1:0] next_id_r, next_id_nxt;
  logic [BURST_W-1:0] cnt_r, cnt_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  res_data_r;
  logic [STAT_W-1:0]  res_status_r;
  logic               res_last_r;
  logic               res_rel_r;
  logic [IDENT_W-1:0] res_ident_r;
  logic [FILL_W-1:0]  res_fill_r;

  logic               load;
  logic [BYTE_W-1:0]  res_data;
  status_t            res_status;
  logic               res_last;
  logic               res_rel;

  // Burst length: clamp the request, then limit it to the bytes held
  logic [BURST_W-1:0] rlen_c;
  logic [CMP_W-1:0]   rlen_x;
  logic [CMP_W-1:0]   held_x;
  logic [BURST_W-1:0] burst_n;
  logic [CNT_W-1:0]   refs_dec;

  assign rlen_c  = (read_len > RLEN_W'(MAX_READ_BURST)) ? BURST_W'(MAX_READ_BURST)
                                                         : BURST_W'(read_len);
  assign rlen_x  = CMP_W'(rlen_c);
  assign held_x  = CMP_W'(held_r);
  assign burst_n = (held_x < rlen_x) ? BURST_W'(held_x) : rlen_c;
  assign refs_dec = sat_dec(refs_r);

  // Status to the controller
  assign stat.slot_free = !out_valid_r || out_tready;
  assign stat.burst_req = (kind == K_READ) && live_r && (held_r != '0) && (burst_n != '0);
  assign stat.last_byte = (cnt_r == BURST_W'(1));

  // Next state and result of the item or burst byte
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    held_nxt    = held_r;
    rdr_nxt     = rdr_r;
    wrr_nxt     = wrr_r;
    refs_nxt    = refs_r;
    live_nxt    = live_r;
    cur_id_nxt  = cur_id_r;
    next_id_nxt = next_id_r;
    cnt_nxt     = cnt_r;
    wr_en       = 1'b0;
    load        = 1'b0;
    res_data    = '0;
    res_status  = S_OK;
    res_last    = 1'b1;
    res_rel     = 1'b0;

    if (cmd.accept && stat.burst_req) begin
      // start a read burst; bytes follow from the store
      cnt_nxt = burst_n;
    end else if (cmd.accept) begin
      load = 1'b1;
      if (kind == K_CREATE) begin
        head_nxt    = '0;
        tail_nxt    = '0;
        held_nxt    = '0;
        rdr_nxt     = '0;
        wrr_nxt     = '0;
        refs_nxt    = '0;
        live_nxt    = 1'b1;
        cur_id_nxt  = next_id_r;
        next_id_nxt = next_id_r + IDENT_W'(1);
      end else if (kind > K_ABORT) begin
        // meaningless kind: plain ok
        res_status = S_OK;
      end else if (!live_r) begin
        res_status = S_NOT_OPEN;
      end else begin
        unique case (kind_t'(kind))
          K_ACQ_READ: begin
            refs_nxt = sat_inc(refs_r);
            rdr_nxt  = sat_inc(rdr_r);
          end
          K_ACQ_WRITE: begin
            refs_nxt = sat_inc(refs_r);
            wrr_nxt  = sat_inc(wrr_r);
          end
          K_ACQ_REF: begin
            refs_nxt = sat_inc(refs_r);
          end
          K_CLS_READ, K_CLS_WRITE: begin
            if (refs_dec == '0) begin
              head_nxt = '0;
              tail_nxt = '0;
              held_nxt = '0;
              rdr_nxt  = '0;
              wrr_nxt  = '0;
              refs_nxt = '0;
              live_nxt = 1'b0;
              res_rel  = 1'b1;
            end else begin
              refs_nxt = refs_dec;
              if (kind == K_CLS_READ) begin
                rdr_nxt = sat_dec(rdr_r);
              end else begin
                wrr_nxt = sat_dec(wrr_r);
              end
            end
          end
          K_WRITE: begin
            if (rdr_r == '0) begin
              res_status = S_BROKEN;
            end else if (held_r >= HELD_W'(BUFFER_BYTES)) begin
              res_status = S_BLOCK;
            end else begin
              wr_en    = 1'b1;
              tail_nxt = ptr_next(tail_r);
              held_nxt = held_r + HELD_W'(1);
            end
          end
          K_READ: begin
            // only reads that deliver nothing get here
            if (held_r == '0) begin
              res_status = (wrr_r == '0) ? S_EOF : S_BLOCK;
            end
          end
          K_ABORT: begin
            head_nxt = '0;
            tail_nxt = '0;
            held_nxt = '0;
            rdr_nxt  = '0;
            wrr_nxt  = '0;
            refs_nxt = '0;
            live_nxt = 1'b0;
            res_rel  = 1'b1;
          end
          default: begin
            res_status = S_OK;
          end
        endcase
      end
    end else if (cmd.pop) begin
      // deliver one byte of the burst
      load     = 1'b1;
      res_data = rd_data_r;
      res_last = stat.last_byte;
      head_nxt = ptr_next(head_r);
      held_nxt = held_r - HELD_W'(1);
      cnt_nxt  = cnt_r - BURST_W'(1);
    end

    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Keep the read port on the head entry
  assign rd_addr = head_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[tail_r] <= data_in;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      rdr_r       <= '0;
      wrr_r       <= '0;
      refs_r      <= '0;
      live_r      <= 1'b0;
      cur_id_r    <= '0;
      next_id_r   <= IDENT_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      rdr_r       <= rdr_nxt;
      wrr_r       <= wrr_nxt;
      refs_r      <= refs_nxt;
      live_r      <= live_nxt;
      cur_id_r    <= cur_id_nxt;
      next_id_r   <= next_id_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_data_r   <= res_data;
      res_status_r <= res_status;
      res_last_r   <= res_last;
      res_rel_r    <= res_rel;
      res_ident_r  <= cur_id_nxt;
      res_fill_r   <= FILL_W'(held_nxt);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_data     = res_data_r;
  assign out_status   = res_status_r;
  assign out_last     = res_last_r;
  assign out_released = res_rel_r;
  assign out_ident    = res_ident_r;
  assign out_fill     = res_fill_r;

endmodule

/* src/pipe_fifo_endpoint_engine.sv */
// Top level of the pipe endpoint engine: stream ports, controller and datapath.
// Depends on pfe_pkg, pfe_ctrl, pfe_dp and assert_macros.svh.
//
// One pipe instance: a byte ring buffer with reader, writer and reference counts.
// Items arrive on the in_ stream (kind in in_tuser, byte and read length in
// in_tdata); results leave on the out_ stream, in_tlast-free, with out_tlast on
// the final result of each item and status/released in out_tuser.
// Output: a result sits in the output register in the cycle after its transfer;
// the first byte of a delivering read passes the byte store's read register first.
// Input: a new item can be taken every clock, except during a delivering read
// or while the receiver stalls, so writes can stream back to back. A delivering
// read holds the input through its transfer and then its bytes, one byte per
// cycle while the receiver takes them, through the single read port of the
// byte store, whose registered data is kept on the head entry.
// A result waiting in the output register does not block the next transfer as
// long as out_tready takes it the same cycle; while the receiver stalls, the
// output register holds and in_tready drops.
// Reset (rst_n low, synchronous) empties the pipe, marks it not open, sets the
// identifier to zero and the next one to one. The byte store is not cleared;
// only written entries are ever read.
`include "assert_macros.svh"
module pipe_fifo_endpoint_engine import pfe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_in[7:0], read_len[14:8], zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[3:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out[7:0], pipe_ident[39:8],
                                             // fill_level[52:40], zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // status[2:0], released[3]
  output logic                   out_tlast
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_in;
  logic [RLEN_W-1:0]  read_len;
  logic [BYTE_W-1:0]  data_out;
  logic [STAT_W-1:0]  status;
  logic               released;
  logic [IDENT_W-1:0] pipe_ident;
  logic [FILL_W-1:0]  fill_level;

  // Unpack the input transfer
  assign kind     = in_tuser;
  assign data_in  = in_tdata[BYTE_W-1:0];
  assign read_len = in_tdata[BYTE_W+RLEN_W-1:BYTE_W];

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfe_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .data_in      (data_in),
    .read_len     (read_len),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_data     (data_out),
    .out_status   (status),
    .out_last     (out_tlast),
    .out_released (released),
    .out_ident    (pipe_ident),
    .out_fill     (fill_level)
  );

  // Pack the result transfer
  assign out_tdata = {{OUT_PAD_W{1'b0}}, fill_level, pipe_ident, data_out};
  assign out_tuser = {released, status};

  // A result that is not the last of its item means a burst is running
  `PFE_ASSERT_IMP(a_burst_blocks_input, clk, rst_n, out_tvalid && !out_tlast, !in_tready)
  // A delivering read closes the input for at least the next cycle
  `PFE_ASSERT_NXT(a_burst_start, clk, rst_n, in_tvalid && in_tready && stat.burst_req, !in_tready)
  // A released pipe holds no bytes
  `PFE_ASSERT_IMP(a_release_empty, clk, rst_n, out_tvalid && released, fill_level == '0)

endmodule
